// ===== src/hrbp_pkg.sv =====
// Shared types and constants for the HTTP request byte parser.
`default_nettype none
package hrbp_pkg;

  // Byte roles
  localparam logic [2:0] ROLE_IGNORED = 3'd0;
  localparam logic [2:0] ROLE_METHOD  = 3'd1;
  localparam logic [2:0] ROLE_TARGET  = 3'd2;
  localparam logic [2:0] ROLE_VERSION = 3'd3;
  localparam logic [2:0] ROLE_NAME    = 3'd4;
  localparam logic [2:0] ROLE_VALUE   = 3'd5;
  localparam logic [2:0] ROLE_BODY    = 3'd6;
  localparam logic [2:0] ROLE_DELIM   = 3'd7;

  // Method codes
  localparam logic [2:0] METH_UNKNOWN     = 3'd0;
  localparam logic [2:0] METH_GET         = 3'd1;
  localparam logic [2:0] METH_HEAD        = 3'd2;
  localparam logic [2:0] METH_POST        = 3'd3;
  localparam logic [2:0] METH_UNSUPPORTED = 3'd4;

  // Parse status codes
  localparam logic [1:0] STAT_BUSY  = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_ERROR = 2'd2;

  // Characters
  localparam logic [7:0] CH_HT    = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Class flags worked out by the front end for one byte
  typedef struct packed {
    logic is_tchar;
    logic is_text;
    logic is_print;
    logic is_digit;
    logic is_sp;
    logic is_cr;
    logic is_lf;
    logic is_colon;
    logic is_dot;
  } hrbp_class_t;

  // One beat as it travels through the queue
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        buffer_last;
    hrbp_class_t cls;
  } hrbp_item_t;

endpackage
`default_nettype wire

// ===== src/hrbp_front.sv =====
// Front end: accepts input beats and classifies each byte.
`default_nettype none
module hrbp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [7:0]        data_byte,
  input  wire logic              buffer_last,
  output logic                   full,
  output logic                   q_push,
  output hrbp_pkg::hrbp_item_t   q_item,
  input  wire logic              q_full
);
  import hrbp_pkg::*;

  logic        f_valid;
  logic        load;
  hrbp_item_t  item;
  hrbp_class_t cls_now;

  function automatic hrbp_class_t classify(input logic [7:0] b);
    hrbp_class_t c;
    logic ctrl;
    logic sep;
    ctrl = (b <= 8'd31) || (b == 8'd127);
    case (b)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09, 8'h3F: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    c.is_tchar = (b <= 8'd127) && !ctrl && !sep;
    c.is_text  = !ctrl || (b == CH_HT);
    c.is_print = (b >= 8'd32) && (b <= 8'd126);
    c.is_digit = (b >= 8'h30) && (b <= 8'h39);
    c.is_sp    = (b == CH_SP);
    c.is_cr    = (b == CH_CR);
    c.is_lf    = (b == CH_LF);
    c.is_colon = (b == CH_COLON);
    c.is_dot   = (b == CH_DOT);
    return c;
  endfunction

  assign cls_now = classify(data_byte);
  assign full    = f_valid && q_full;
  assign load    = push && !full;
  assign q_push  = f_valid && !q_full;
  assign q_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= load || (f_valid && q_full);
    end
    if (load) begin
      item.data_byte   <= data_byte;
      item.buffer_last <= buffer_last;
      item.cls         <= cls_now;
    end
  end

endmodule
`default_nettype wire

// ===== src/hrbp_queue.sv =====
// Short FIFO between the classifier and the parse state machine.
`default_nettype none
module hrbp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire hrbp_pkg::hrbp_item_t wr_item,
  output logic                      q_full,
  input  wire logic                 rd_en,
  output hrbp_pkg::hrbp_item_t      rd_item,
  output logic                      q_empty
);
  import hrbp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  hrbp_item_t      slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign q_full  = (count == FULL_CNT);
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ===== src/hrbp_back.sv =====
// Back end: request parse state machine and result register.
`default_nettype none
module hrbp_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire hrbp_pkg::hrbp_item_t q_item,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  input  wire logic                 pop,
  output logic                      empty,
  output logic [2:0]                byte_role,
  output logic [2:0]                method_code,
  output logic [1:0]                parse_status,
  output logic                      header_complete,
  output logic [7:0]                byte_out
);
  import hrbp_pkg::*;

  typedef enum logic [4:0] {
    S_LINE_BEGIN, S_METHOD, S_TARGET, S_PROTO_H, S_PROTO_T1, S_PROTO_T2,
    S_PROTO_P, S_PROTO_SLASH, S_MAJOR, S_MINOR, S_LINE_LF, S_NAME_BEGIN,
    S_NAME, S_VALUE, S_VALUE_LF, S_END_LF, S_CONTENT, S_DONE, S_ERROR
  } state_t;

  localparam logic [3:0]  CL_LEN     = 4'd14;
  localparam logic [31:0] WORD_GET   = 32'h0054_4547;
  localparam logic [31:0] WORD_HEAD  = 32'h4441_4548;
  localparam logic [31:0] WORD_POST  = 32'h5453_4F50;

  function automatic logic [7:0] cl_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:  c = 8'h43; // C
      4'd1:  c = 8'h6F; // o
      4'd2:  c = 8'h6E; // n
      4'd3:  c = 8'h74; // t
      4'd4:  c = 8'h65; // e
      4'd5:  c = 8'h6E; // n
      4'd6:  c = 8'h74; // t
      4'd7:  c = 8'h2D; // -
      4'd8:  c = 8'h4C; // L
      4'd9:  c = 8'h65; // e
      4'd10: c = 8'h6E; // n
      4'd11: c = 8'h67; // g
      4'd12: c = 8'h74; // t
      4'd13: c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  state_t      state, state_next;
  logic [31:0] method_chars, method_chars_next;
  logic [2:0]  method_length, method_length_next;
  logic [2:0]  method_kind, method_kind_next;
  logic [3:0]  name_idx, name_idx_next;
  logic        name_ok, name_ok_next;
  logic        length_seen, length_seen_next;
  logic        out_valid;
  logic        take;
  logic [2:0]  role;
  logic        hdr_done;
  logic [2:0]  decided;
  logic [7:0]  b;
  hrbp_class_t c;

  assign b     = q_item.data_byte;
  assign c     = q_item.cls;
  assign take  = !q_empty && (!out_valid || pop);
  assign q_pop = take;
  assign empty = !out_valid;

  always_comb begin
    if (method_length >= 3'd3 && method_chars[23:0] == WORD_GET[23:0]) begin
      decided = METH_GET;
    end else if (method_length >= 3'd4 && method_chars == WORD_HEAD) begin
      decided = METH_HEAD;
    end else if (method_length >= 3'd4 && method_chars == WORD_POST) begin
      decided = METH_POST;
    end else begin
      decided = METH_UNSUPPORTED;
    end
  end

  always_comb begin
    logic take_m;
    logic take_n;
    logic fresh_n;
    take_m             = 1'b0;
    take_n             = 1'b0;
    fresh_n            = 1'b0;
    state_next         = S_ERROR;
    role               = ROLE_IGNORED;
    hdr_done           = 1'b0;
    method_chars_next  = method_chars;
    method_length_next = method_length;
    method_kind_next   = method_kind;
    name_idx_next      = name_idx;
    name_ok_next       = name_ok;
    length_seen_next   = length_seen;
    case (state)
      S_LINE_BEGIN: begin
        if (c.is_tchar) begin
          take_m = 1'b1; role = ROLE_METHOD; state_next = S_METHOD;
        end
      end
      S_METHOD: begin
        if (c.is_sp) begin
          method_kind_next = decided; role = ROLE_DELIM; state_next = S_TARGET;
        end else if (c.is_tchar) begin
          take_m = 1'b1; role = ROLE_METHOD; state_next = S_METHOD;
        end
      end
      S_TARGET: begin
        if (c.is_sp) begin
          role = ROLE_DELIM; state_next = S_PROTO_H;
        end else if (c.is_print) begin
          role = ROLE_TARGET; state_next = S_TARGET;
        end
      end
      S_PROTO_H: begin
        if (b == 8'h48) begin
          role = ROLE_VERSION; state_next = S_PROTO_T1;
        end
      end
      S_PROTO_T1: begin
        if (b == 8'h54) begin
          role = ROLE_VERSION; state_next = S_PROTO_T2;
        end
      end
      S_PROTO_T2: begin
        if (b == 8'h54) begin
          role = ROLE_VERSION; state_next = S_PROTO_P;
        end
      end
      S_PROTO_P: begin
        if (b == 8'h50) begin
          role = ROLE_VERSION; state_next = S_PROTO_SLASH;
        end
      end
      S_PROTO_SLASH: begin
        if (b == CH_SLASH) begin
          role = ROLE_VERSION; state_next = S_MAJOR;
        end
      end
      S_MAJOR: begin
        if (c.is_digit) begin
          role = ROLE_VERSION; state_next = S_MAJOR;
        end else if (c.is_dot) begin
          role = ROLE_VERSION; state_next = S_MINOR;
        end
      end
      S_MINOR: begin
        if (c.is_digit || c.is_dot) begin
          role = ROLE_VERSION; state_next = S_MINOR;
        end else if (c.is_cr) begin
          role = ROLE_DELIM; state_next = S_LINE_LF;
        end
      end
      S_LINE_LF: begin
        if (c.is_lf) begin
          role = ROLE_DELIM; state_next = S_NAME_BEGIN;
        end
      end
      S_NAME_BEGIN: begin
        if (c.is_tchar) begin
          fresh_n = 1'b1; role = ROLE_NAME; state_next = S_NAME;
        end else if (c.is_cr) begin
          role = ROLE_DELIM; state_next = S_END_LF;
        end
      end
      S_NAME: begin
        if (c.is_tchar) begin
          take_n = 1'b1; role = ROLE_NAME; state_next = S_NAME;
        end else if (c.is_colon) begin
          role = ROLE_DELIM; state_next = S_VALUE;
        end
      end
      S_VALUE: begin
        if (c.is_cr) begin
          role = ROLE_DELIM; state_next = S_VALUE_LF;
        end else if (c.is_text) begin
          role = ROLE_VALUE; state_next = S_VALUE;
        end
      end
      S_VALUE_LF: begin
        if (c.is_lf) begin
          if (name_ok && name_idx == CL_LEN) begin
            length_seen_next = 1'b1;
          end
          hdr_done = 1'b1; role = ROLE_DELIM; state_next = S_NAME_BEGIN;
        end
      end
      S_END_LF: begin
        if (c.is_lf) begin
          if (method_kind == METH_GET || method_kind == METH_HEAD) begin
            role = ROLE_DELIM; state_next = S_DONE;
          end else if (method_kind == METH_POST && length_seen) begin
            role = ROLE_DELIM; state_next = S_CONTENT;
          end
        end
      end
      S_CONTENT: begin
        role       = ROLE_BODY;
        state_next = q_item.buffer_last ? S_DONE : S_CONTENT;
      end
      S_DONE: begin
        state_next = S_DONE;
      end
      default: begin
        state_next = S_ERROR;
      end
    endcase

    if (take_m) begin
      case (method_length)
        3'd0: method_chars_next[7:0]   = b;
        3'd1: method_chars_next[15:8]  = b;
        3'd2: method_chars_next[23:16] = b;
        3'd3: method_chars_next[31:24] = b;
        default: method_chars_next = method_chars;
      endcase
      if (method_length != 3'd7) begin
        method_length_next = method_length + 3'd1;
      end
    end

    // A new header name restarts the Content-Length match
    if (fresh_n) begin
      name_idx_next = (b == cl_char(4'd0)) ? 4'd1 : 4'd0;
      name_ok_next  = (b == cl_char(4'd0));
    end else if (take_n) begin
      if (name_ok && name_idx < CL_LEN && b == cl_char(name_idx)) begin
        name_idx_next = name_idx + 4'd1;
      end else begin
        name_ok_next = 1'b0;
      end
    end

    if (state_next == S_ERROR) begin
      role     = ROLE_IGNORED;
      hdr_done = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LINE_BEGIN;
      method_chars  <= '0;
      method_length <= '0;
      method_kind   <= METH_UNKNOWN;
      name_idx      <= '0;
      name_ok       <= 1'b1;
      length_seen   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        state         <= state_next;
        method_chars  <= method_chars_next;
        method_length <= method_length_next;
        method_kind   <= method_kind_next;
        name_idx      <= name_idx_next;
        name_ok       <= name_ok_next;
        length_seen   <= length_seen_next;
        out_valid     <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
    if (take) begin
      byte_role       <= role;
      method_code     <= method_kind_next;
      header_complete <= hdr_done;
      byte_out        <= b;
      if (state_next == S_DONE) begin
        parse_status <= STAT_DONE;
      end else if (state_next == S_ERROR) begin
        parse_status <= STAT_ERROR;
      end else begin
        parse_status <= STAT_BUSY;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/http_request_byte_parser.sv =====
// Top level of the HTTP/1.1 request byte parser.
//
//   channel  | handshake          | beat payload
//   ---------+--------------------+------------------------------------------
//   input    | push / full        | data_byte[7:0], buffer_last
//   result   | pop / empty        | byte_role[2:0], method_code[2:0],
//            |                    | parse_status[1:0], header_complete,
//            |                    | byte_out[7:0]
//
// One result beat per input beat, one beat per cycle sustained while the result side keeps popping.
// With no stalls, an accepted beat passes the classify register, a queue slot
// and then the state machine's result register before its result is visible.
// The state machine walks request line, headers and body one byte a cycle while
// it is not stalled; its single next-state decision per byte sets the rate.
// rst is synchronous: queue and classify register empty, parser back at the request line start.
// A stalled result side fills the result register, then the queue
// (QUEUE_DEPTH beats), then the classify register before full rises.
`default_nettype none
module http_request_byte_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte,
  input  wire logic       buffer_last,
  input  wire logic       pop,
  output logic            empty,
  output logic [2:0]      byte_role,
  output logic [2:0]      method_code,
  output logic [1:0]      parse_status,
  output logic            header_complete,
  output logic [7:0]      byte_out
);
  import hrbp_pkg::*;

  logic       q_wr;
  logic       q_full;
  logic       q_rd;
  logic       q_empty;
  hrbp_item_t q_in;
  hrbp_item_t q_out;

  // Classify bytes on the way in
  hrbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .data_byte   (data_byte),
    .buffer_last (buffer_last),
    .full        (full),
    .q_push      (q_wr),
    .q_item      (q_in),
    .q_full      (q_full)
  );

  // Decouples classification from parsing
  hrbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_item (q_in),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .rd_item (q_out),
    .q_empty (q_empty)
  );

  // Parse state machine and result register
  hrbp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_item          (q_out),
    .q_empty         (q_empty),
    .q_pop           (q_rd),
    .pop             (pop),
    .empty           (empty),
    .byte_role       (byte_role),
    .method_code     (method_code),
    .parse_status    (parse_status),
    .header_complete (header_complete),
    .byte_out        (byte_out)
  );

endmodule
`default_nettype wire

// ===== src/hrbp_checker.sv =====
// Port-level checks for the HTTP request byte parser, bound to the top level.
`default_nettype none
module hrbp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       pop,
  input wire logic       empty,
  input wire logic [2:0] byte_role,
  input wire logic [2:0] method_code,
  input wire logic [1:0] parse_status,
  input wire logic       header_complete,
  input wire logic [7:0] byte_out
);
  import hrbp_pkg::*;

  // Nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(byte_out) && $stable(byte_role)))
    else $error("stalled result changed");

  // Offending and later bytes carry no role
  a_err_ignored: assert property (@(posedge clk) disable iff (rst)
    (!empty && parse_status == STAT_ERROR) |->
      (byte_role == ROLE_IGNORED && !header_complete))
    else $error("error beat has a role");

  // Header line close is a delimiter LF
  a_hdr_lf: assert property (@(posedge clk) disable iff (rst)
    (!empty && header_complete) |->
      (byte_out == CH_LF && byte_role == ROLE_DELIM && parse_status == STAT_BUSY))
    else $error("header_complete on a wrong byte");

  // Body bytes only follow a POST
  a_body_post: assert property (@(posedge clk) disable iff (rst)
    (!empty && byte_role == ROLE_BODY) |-> (method_code == METH_POST))
    else $error("body byte without POST");

endmodule

bind http_request_byte_parser hrbp_checker u_hrbp_checker (
  .clk             (clk),
  .rst             (rst),
  .pop             (pop),
  .empty           (empty),
  .byte_role       (byte_role),
  .method_code     (method_code),
  .parse_status    (parse_status),
  .header_complete (header_complete),
  .byte_out        (byte_out)
);
`default_nettype wire

// ===== verif/http_request_byte_parser_tb.sv =====
// Self-checking testbench for the HTTP request byte parser.
`timescale 1ns / 100ps
module http_request_byte_parser_tb;
  import hrbp_pkg::*;

  // Run limits. The slowest correct run has about 1400 beats, idling on
  // both sides and one long result stall.
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int TARGET_BEATS = 1350;
  localparam int STALL_CYCLES = 150;
  localparam int STALL_AT     = 200;
  localparam int IDLE_PCT     = 16;

  // "Content-Length", first character in the top byte
  localparam logic [111:0] LEN_NAME = "Content-Length";
  localparam int LEN_NAME_CHARS = 14;

  typedef enum logic [4:0] {
    PS_LINE_BEGIN, PS_METHOD, PS_TARGET, PS_PROTO_H, PS_PROTO_T1, PS_PROTO_T2,
    PS_PROTO_P, PS_PROTO_SLASH, PS_MAJOR, PS_MINOR, PS_LINE_LF, PS_NAME_BEGIN,
    PS_NAME, PS_VALUE, PS_VALUE_LF, PS_END_LF, PS_CONTENT, PS_DONE, PS_ERROR
  } parse_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } req_beat_t;

  typedef struct packed {
    logic [2:0] role;
    logic [2:0] meth;
    logic [1:0] status;
    logic       hdr_done;
    logic [7:0] echo;
  } parse_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       buffer_last = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [2:0] byte_role;
  logic [2:0] method_code;
  logic [1:0] parse_status;
  logic       header_complete;
  logic [7:0] byte_out;

  http_request_byte_parser DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .data_byte(data_byte), .buffer_last(buffer_last),
    .pop(pop), .empty(empty), .byte_role(byte_role), .method_code(method_code),
    .parse_status(parse_status), .header_complete(header_complete),
    .byte_out(byte_out)
  );

  always #4 clk = ~clk;

  // Request stream waiting to be offered, and results owed by the parser
  req_beat_t     request_bytes[$];
  parse_result_t pending_results[$];

  int  total_beats = 0;
  int  beats_in = 0;
  int  cycle_count = 0;
  int  mismatches = 0;
  bit  in_taken = 1'b0;   // input beat accepted at the last rising edge
  int  hold_left = 0;
  bit  held_off = 1'b0;

  // Parser shadow state
  parse_state_e pstate = PS_LINE_BEGIN;
  logic [31:0]  mchars = '0;
  logic [2:0]   mlen = '0;
  logic [2:0]   mkind = METH_UNKNOWN;
  logic [3:0]   name_idx = '0;
  logic         name_ok = 1'b1;
  logic         len_seen = 1'b0;

  // ---------------------------------------------------------------------------
  // Byte classes
  // ---------------------------------------------------------------------------
  function automatic bit is_ctl(input logic [7:0] b);
    return b <= 8'd31 || b == 8'd127;
  endfunction

  function automatic bit is_sep(input logic [7:0] b);
    case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "=",
      "{", "}", "?", CH_SP, CH_HT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_tok(input logic [7:0] b);
    return b <= 8'd127 && !is_ctl(b) && !is_sep(b);
  endfunction

  function automatic bit is_txt(input logic [7:0] b);
    return !is_ctl(b) || b == CH_HT;
  endfunction

  function automatic bit is_dig(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // Method bytes: first four kept, count saturates at 7
  function automatic void note_method_char(input logic [7:0] b);
    if (mlen < 3'd4) mchars[8*mlen +: 8] = b;
    if (mlen < 3'd7) mlen = mlen + 3'd1;
  endfunction

  // Exact-case match against Content-Length, one name byte at a time
  function automatic void note_name_char(input logic [7:0] b);
    if (name_ok && name_idx < LEN_NAME_CHARS &&
        b == LEN_NAME[8*(LEN_NAME_CHARS-1-name_idx) +: 8])
      name_idx = name_idx + 4'd1;
    else
      name_ok = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: advances the shadow parser by one byte, returns the result beat
  // ---------------------------------------------------------------------------
  function automatic parse_result_t parse_byte(input logic [7:0] b, input logic is_last);
    parse_result_t r;
    parse_state_e  nx;
    logic [2:0]    role;
    logic          hdr;
    role = ROLE_IGNORED;
    hdr  = 1'b0;
    nx   = PS_ERROR;
    case (pstate)
      PS_LINE_BEGIN: if (is_tok(b)) begin
        note_method_char(b); role = ROLE_METHOD; nx = PS_METHOD;
      end
      PS_METHOD: if (b == CH_SP) begin
        // GET wins on a three-byte prefix, HEAD and POST need four
        if (mlen >= 3'd3 && mchars[23:0] == {"T", "E", "G"}) mkind = METH_GET;
        else if (mlen >= 3'd4 && mchars == {"D", "A", "E", "H"}) mkind = METH_HEAD;
        else if (mlen >= 3'd4 && mchars == {"T", "S", "O", "P"}) mkind = METH_POST;
        else mkind = METH_UNSUPPORTED;
        role = ROLE_DELIM; nx = PS_TARGET;
      end else if (is_tok(b)) begin
        note_method_char(b); role = ROLE_METHOD; nx = PS_METHOD;
      end
      PS_TARGET: if (b == CH_SP) begin
        role = ROLE_DELIM; nx = PS_PROTO_H;
      end else if (b >= 8'd32 && b <= 8'd126) begin
        role = ROLE_TARGET; nx = PS_TARGET;
      end
      PS_PROTO_H:     if (b == "H") begin role = ROLE_VERSION; nx = PS_PROTO_T1; end
      PS_PROTO_T1:    if (b == "T") begin role = ROLE_VERSION; nx = PS_PROTO_T2; end
      PS_PROTO_T2:    if (b == "T") begin role = ROLE_VERSION; nx = PS_PROTO_P; end
      PS_PROTO_P:     if (b == "P") begin role = ROLE_VERSION; nx = PS_PROTO_SLASH; end
      PS_PROTO_SLASH: if (b == CH_SLASH) begin role = ROLE_VERSION; nx = PS_MAJOR; end
      PS_MAJOR: if (is_dig(b)) begin
        role = ROLE_VERSION; nx = PS_MAJOR;
      end else if (b == CH_DOT) begin
        role = ROLE_VERSION; nx = PS_MINOR;
      end
      PS_MINOR: if (is_dig(b) || b == CH_DOT) begin
        role = ROLE_VERSION; nx = PS_MINOR;
      end else if (b == CH_CR) begin
        role = ROLE_DELIM; nx = PS_LINE_LF;
      end
      PS_LINE_LF: if (b == CH_LF) begin role = ROLE_DELIM; nx = PS_NAME_BEGIN; end
      PS_NAME_BEGIN: if (is_tok(b)) begin
        name_idx = '0;
        name_ok  = 1'b1;
        note_name_char(b);
        role = ROLE_NAME; nx = PS_NAME;
      end else if (b == CH_CR) begin
        role = ROLE_DELIM; nx = PS_END_LF;
      end
      PS_NAME: if (is_tok(b)) begin
        note_name_char(b); role = ROLE_NAME; nx = PS_NAME;
      end else if (b == CH_COLON) begin
        role = ROLE_DELIM; nx = PS_VALUE;
      end
      // CR straight after the colon is an empty value, which is legal
      PS_VALUE: if (b == CH_CR) begin
        role = ROLE_DELIM; nx = PS_VALUE_LF;
      end else if (is_txt(b)) begin
        role = ROLE_VALUE; nx = PS_VALUE;
      end
      PS_VALUE_LF: if (b == CH_LF) begin
        if (name_ok && name_idx == LEN_NAME_CHARS) len_seen = 1'b1;
        hdr = 1'b1; role = ROLE_DELIM; nx = PS_NAME_BEGIN;
      end
      // Blank line: GET/HEAD finish, POST moves on only with a length header
      PS_END_LF: if (b == CH_LF) begin
        if (mkind == METH_GET || mkind == METH_HEAD) begin
          role = ROLE_DELIM; nx = PS_DONE;
        end else if (mkind == METH_POST && len_seen) begin
          role = ROLE_DELIM; nx = PS_CONTENT;
        end
      end
      PS_CONTENT: begin
        role = ROLE_BODY;
        nx = is_last ? PS_DONE : PS_CONTENT;
      end
      PS_DONE: nx = PS_DONE;
      default: nx = PS_ERROR;
    endcase
    pstate = nx;
    if (nx == PS_ERROR) begin
      role = ROLE_IGNORED;
      hdr  = 1'b0;
    end
    r.role     = role;
    r.meth     = mkind;
    r.status   = (nx == PS_DONE) ? STAT_DONE : ((nx == PS_ERROR) ? STAT_ERROR : STAT_BUSY);
    r.hdr_done = hdr;
    r.echo     = b;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders. Outside the body, buffer_last is noise the parser ignores.
  // ---------------------------------------------------------------------------
  function automatic logic stray_last();
    return $urandom_range(0, 7) == 0;
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic is_last);
    req_beat_t beat;
    beat.data    = b;
    beat.is_last = is_last;
    request_bytes.insert(request_bytes.size(), beat);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], stray_last());
  endtask

  task automatic put_token(input int len);
    logic [7:0] b;
    repeat (len) begin
      b = 8'($urandom_range(33, 126));
      while (!is_tok(b)) b = 8'($urandom_range(33, 126));
      put_byte(b, stray_last());
    end
  endtask

  // Value text: printable, HT and the whole upper half
  task automatic put_value(input int len);
    logic [7:0] b;
    repeat (len) begin
      b = 8'($urandom_range(0, 255));
      while (!is_txt(b)) b = 8'($urandom_range(0, 255));
      put_byte(b, stray_last());
    end
  endtask

  task automatic put_request_line();
    int n;
    put_byte(CH_SP, stray_last());
    // target may be empty: two spaces back to back
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    repeat (n) put_byte(8'($urandom_range(33, 126)), stray_last());
    put_byte(CH_SP, stray_last());
    put_text("HTTP/");
    repeat ($urandom_range(1, 2)) put_byte(8'($urandom_range("0", "9")), stray_last());
    put_byte(CH_DOT, stray_last());
    // minor part may be empty, or hold extra dots
    repeat ($urandom_range(0, 3))
      put_byte(($urandom_range(0, 3) == 0) ? CH_DOT : 8'($urandom_range("0", "9")),
               stray_last());
    put_byte(CH_CR, stray_last());
    put_byte(CH_LF, stray_last());
  endtask

  // Header lines up to a beat budget; the first one is Content-Length if wanted
  task automatic put_headers(input int upto, input bit want_length);
    int  k;
    bit  first;
    first = want_length;
    while (request_bytes.size() < upto) begin
      k = first ? 0 : $urandom_range(0, 11);
      first = 1'b0;
      if (k == 0 && want_length) begin
        put_text("Content-Length");
      end else if (k <= 1) begin
        // names that come close to Content-Length but must not count
        case ($urandom_range(0, 3))
          0: put_text("content-length");
          1: put_text("Content-Len");
          2: put_text("Content-Lengths");
          default: put_text("Content-Lengtx");
        endcase
      end else begin
        put_token($urandom_range(1, 12));
      end
      put_byte(CH_COLON, stray_last());
      if ($urandom_range(0, 5) != 0) put_value($urandom_range(1, 16));
      put_byte(CH_CR, stray_last());
      put_byte(CH_LF, stray_last());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Fill the request stream. Done and error are sticky and reset comes once,
  // so a run carries one long request; the seed picks which ending it takes.
  // ---------------------------------------------------------------------------
  initial begin
    int scenario;
    int body_len;
    scenario = $urandom_range(0, 9);
    case (scenario)
      0, 1, 2, 3, 4, 5: put_text("POST");
      6: put_text("GET");
      7: begin
        if ($urandom_range(0, 1) == 0) put_text("HEAD");
        else put_text("GETX");
      end
      8: begin
        // unsupported token, lengths beyond the saturation point too,
        // or a POST that lacks the length header
        if ($urandom_range(0, 1) == 0) put_token($urandom_range(1, 9));
        else put_text("POST");
      end
      default: put_token($urandom_range(1, 5));
    endcase
    put_request_line();

    if (scenario <= 5) begin
      put_headers(TARGET_BEATS / 2, 1'b1);
      put_byte(CH_CR, stray_last());
      put_byte(CH_LF, stray_last());
      // body: both byte extremes first, then random, last byte closes it
      put_byte(8'h00, 1'b0);
      put_byte(8'hFF, 1'b0);
      body_len = TARGET_BEATS - request_bytes.size();
      repeat (body_len - 1) put_byte(8'($urandom_range(0, 255)), 1'b0);
      put_byte(8'($urandom_range(0, 255)), 1'b1);
    end else if (scenario <= 8) begin
      put_headers(TARGET_BEATS - 40, 1'b0);
      put_byte(CH_CR, stray_last());
      put_byte(CH_LF, stray_last());
    end else begin
      // broken tail: random bytes where a header name should start
      put_headers(TARGET_BEATS - 40, 1'($urandom_range(0, 1)));
      repeat (6) put_byte(8'($urandom_range(0, 255)), stray_last());
    end

    // trailing bytes after the parser has settled
    repeat (24) put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    total_beats = request_bytes.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (beats_in != total_beats || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: offers the next beat at the falling edge, holds it until taken.
  // A middle stretch runs with no idling on either side.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    req_beat_t beat;
    bit        steady;
    steady = beats_in >= 600 && beats_in < 900;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      if (request_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        beat = request_bytes.pop_front();
        push        <= 1'b1;
        data_byte   <= beat.data;
        buffer_last <= beat.is_last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random pops, plus one long hold-off so the block backs up
  // and raises full while the sender keeps offering.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    bit steady;
    steady = beats_in >= 600 && beats_in < 900;
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else if (!held_off && beats_in >= STALL_AT) begin
      held_off  = 1'b1;
      hold_left = STALL_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, predict for an accepted input beat and
  // check an accepted result beat against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    parse_result_t want;
    cycle_count = cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      in_taken = push && !full;
      if (in_taken) begin
        pending_results.insert(pending_results.size(), parse_byte(data_byte, buffer_last));
        beats_in = beats_in + 1;
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: byte_out %0d", byte_out);
          mismatches = mismatches + 1;
        end else begin
          want = pending_results.pop_front();
          if (byte_role !== want.role) begin
            $error("byte_role: expected %0d, got %0d", want.role, byte_role);
            mismatches = mismatches + 1;
          end
          if (method_code !== want.meth) begin
            $error("method_code: expected %0d, got %0d", want.meth, method_code);
            mismatches = mismatches + 1;
          end
          if (parse_status !== want.status) begin
            $error("parse_status: expected %0d, got %0d", want.status, parse_status);
            mismatches = mismatches + 1;
          end
          if (header_complete !== want.hdr_done) begin
            $error("header_complete: expected %0d, got %0d", want.hdr_done, header_complete);
            mismatches = mismatches + 1;
          end
          if (byte_out !== want.echo) begin
            $error("byte_out: expected %0d, got %0d", want.echo, byte_out);
            mismatches = mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ===== files.f =====
src/hrbp_pkg.sv
src/hrbp_front.sv
src/hrbp_queue.sv
src/hrbp_back.sv
src/http_request_byte_parser.sv
src/hrbp_checker.sv
verif/http_request_byte_parser_tb.sv
